// File: rtl/core/tdpc_pkg.sv
// Shared types, constants and the sequencer program of the trial-division prime counter.
package tdpc_pkg;

  localparam int TABLE_DEPTH_DEF    = 8192;
  localparam int CANDIDATE_BITS_DEF = 32;
  localparam int PRIME_W            = 16;
  localparam int COUNT_W            = 32;

  typedef struct packed {
    logic [31:0] candidate;
    logic        restart;
  } tdpc_in_t;

  typedef struct packed {
    logic               is_prime;
    logic [COUNT_W-1:0] prime_count;
    logic               table_overflow;
  } tdpc_out_t;

  typedef struct packed {
    logic busy;
    logic rem_zero;
  } tdpc_div_sts_t;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'd0,
    ST_CHK   = 4'd1,
    ST_LOOP  = 4'd2,
    ST_DIV   = 4'd3,
    ST_WAIT  = 4'd4,
    ST_TEST  = 4'd5,
    ST_NEXT  = 4'd6,
    ST_PRIME = 4'd7,
    ST_COMP  = 4'd8
  } tdpc_step_t;

  typedef enum logic [2:0] {
    C_ALWAYS,
    C_NO_START,
    C_SMALL,
    C_END,
    C_SELF,
    C_DIV_BUSY,
    C_REM_ZERO
  } tdpc_cond_t;

  typedef struct packed {
    tdpc_cond_t cond;
    tdpc_step_t target;
    logic       rd;
    logic       divgo;
    logic       kinc;
    logic       prime;
    logic       comp;
  } tdpc_uword_t;

  // Control store: jump to target when cond holds, else fall through.
  function automatic tdpc_uword_t tdpc_ucode(tdpc_step_t s);
    tdpc_uword_t w;
    w = '{cond: C_ALWAYS, target: ST_IDLE, rd: 1'b0, divgo: 1'b0,
          kinc: 1'b0, prime: 1'b0, comp: 1'b0};
    case (s)
      ST_IDLE: begin
        w.cond = C_NO_START;
        w.target = ST_IDLE;
      end
      ST_CHK: begin
        w.cond = C_SMALL;
        w.target = ST_COMP;
      end
      ST_LOOP: begin
        w.cond = C_END;
        w.target = ST_PRIME;
        w.rd = 1'b1;
      end
      ST_DIV: begin
        w.cond = C_SELF;
        w.target = ST_NEXT;
        w.divgo = 1'b1;
      end
      ST_WAIT: begin
        w.cond = C_DIV_BUSY;
        w.target = ST_WAIT;
      end
      ST_TEST: begin
        w.cond = C_REM_ZERO;
        w.target = ST_COMP;
      end
      ST_NEXT: begin
        w.target = ST_LOOP;
        w.kinc = 1'b1;
      end
      ST_PRIME: begin
        w.target = ST_IDLE;
        w.prime = 1'b1;
      end
      ST_COMP: begin
        w.target = ST_IDLE;
        w.comp = 1'b1;
      end
      default: begin
        w.target = ST_IDLE;
      end
    endcase
    return w;
  endfunction

endpackage

// File: rtl/core/tdpc_mod.sv
// Bit-serial restoring remainder unit: candidate modulo a 16-bit divisor.
module tdpc_mod import tdpc_pkg::*; #(
  parameter int CW = CANDIDATE_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               go,
  input  logic [CW-1:0]      dividend,
  input  logic [PRIME_W-1:0] divisor,
  output tdpc_div_sts_t      sts
);

  localparam int CNTW = $clog2(CW + 1);

  logic [CNTW-1:0]    cnt_r, cnt_nxt;
  logic [CW-1:0]      dvd_r, dvd_nxt;
  logic [PRIME_W-1:0] dvs_r, dvs_nxt;
  logic [PRIME_W-1:0] rem_r, rem_nxt;
  logic [PRIME_W:0]   trial;

  always_comb begin
    cnt_nxt = cnt_r;
    dvd_nxt = dvd_r;
    dvs_nxt = dvs_r;
    rem_nxt = rem_r;
    trial   = {rem_r, dvd_r[CW-1]};
    if (go) begin
      cnt_nxt = CNTW'(CW);
      dvd_nxt = dividend;
      dvs_nxt = divisor;
      rem_nxt = '0;
    end else if (cnt_r != '0) begin
      cnt_nxt = cnt_r - CNTW'(1);
      dvd_nxt = dvd_r << 1;
      if (trial >= {1'b0, dvs_r}) begin
        rem_nxt = PRIME_W'(trial - {1'b0, dvs_r});
      end else begin
        rem_nxt = trial[PRIME_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
    dvd_r <= dvd_nxt;
    dvs_r <= dvs_nxt;
    rem_r <= rem_nxt;
  end

  assign sts.busy     = (cnt_r != '0);
  assign sts.rem_zero = (rem_r == '0);

endmodule

// File: rtl/core/trial_division_prime_counter_top.sv
// Top level of the trial-division prime counter: sequencer, prime table and result register.
// Raise start with a candidate while busy is low; the result appears on out_beat for one
// cycle with out_strobe and cannot be held off. For each stored prime tried, the bit-serial
// remainder unit steps through the CW candidate bits, CW being CANDIDATE_BITS capped at 32;
// an entry equal to the candidate is skipped without a division; a composite stops at its
// first dividing prime. The walk over the prime table, one entry per remainder, sets the rate.
// Software supplies root_limit through cfg_we/cfg_wdata; primes up to it are stored, while
// the table has room, for later candidates.
module trial_division_prime_counter_top import tdpc_pkg::*; #(
  parameter int TABLE_DEPTH    = TABLE_DEPTH_DEF,
  parameter int CANDIDATE_BITS = CANDIDATE_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  tdpc_in_t           in_beat,
  output logic               out_strobe,
  output tdpc_out_t          out_beat,
  input  logic               cfg_we,
  input  logic [PRIME_W-1:0] cfg_wdata
);

  localparam int CW   = (CANDIDATE_BITS < 32) ? CANDIDATE_BITS : 32;
  localparam int AW   = $clog2(TABLE_DEPTH);
  localparam int FW   = $clog2(TABLE_DEPTH + 1);
  localparam int CMPW = (CW > PRIME_W) ? CW : PRIME_W;

  logic [PRIME_W-1:0] mem [TABLE_DEPTH];
  logic [PRIME_W-1:0] rd_data_r;

  tdpc_step_t         pc_r, pc_nxt;
  logic [CW-1:0]      cand_r, cand_nxt;
  logic [FW-1:0]      fill_r, fill_nxt;
  logic [FW-1:0]      k_r, k_nxt;
  logic [COUNT_W-1:0] count_r, count_nxt;
  logic [PRIME_W-1:0] root_r;
  logic               out_strobe_r, out_strobe_nxt;
  tdpc_out_t          out_beat_r, out_beat_nxt;

  tdpc_uword_t   uw;
  tdpc_div_sts_t div_sts;
  logic          take;
  logic          div_go;
  logic          mem_we;
  logic          fits_root;
  logic          has_room;

  tdpc_mod #(.CW(CW)) u_mod (
    .clk      (clk),
    .rst_n    (rst_n),
    .go       (div_go),
    .dividend (cand_r),
    .divisor  (rd_data_r),
    .sts      (div_sts)
  );

  assign uw        = tdpc_ucode(pc_r);
  assign fits_root = (CMPW'(cand_r) <= CMPW'(root_r));
  assign has_room  = (fill_r < FW'(TABLE_DEPTH));

  always_comb begin
    case (uw.cond)
      C_ALWAYS:   take = 1'b1;
      C_NO_START: take = !start;
      C_SMALL:    take = (cand_r < CW'(2));
      C_END:      take = (k_r == fill_r);
      C_SELF:     take = (CMPW'(rd_data_r) == CMPW'(cand_r));
      C_DIV_BUSY: take = div_sts.busy;
      C_REM_ZERO: take = div_sts.rem_zero;
      default:    take = 1'b0;
    endcase
  end

  assign div_go = uw.divgo && !take;
  assign mem_we = uw.prime && fits_root && has_room;
  assign busy   = (pc_r != ST_IDLE);

  always_comb begin
    pc_nxt         = take ? uw.target : tdpc_step_t'(4'(pc_r + 4'd1));
    cand_nxt       = cand_r;
    fill_nxt       = fill_r;
    k_nxt          = k_r;
    count_nxt      = count_r;
    out_strobe_nxt = 1'b0;
    out_beat_nxt   = out_beat_r;
    if (pc_r == ST_IDLE && start) begin
      cand_nxt = in_beat.candidate[CW-1:0];
      k_nxt    = '0;
      if (in_beat.restart) begin
        fill_nxt  = '0;
        count_nxt = '0;
      end
    end
    if (uw.kinc) begin
      k_nxt = k_r + FW'(1);
    end
    if (uw.prime) begin
      if (count_r != '1) begin
        count_nxt = count_r + COUNT_W'(1);
      end
      if (mem_we) begin
        fill_nxt = fill_r + FW'(1);
      end
      out_strobe_nxt              = 1'b1;
      out_beat_nxt.is_prime       = 1'b1;
      out_beat_nxt.prime_count    = count_nxt;
      out_beat_nxt.table_overflow = fits_root && !has_room;
    end
    if (uw.comp) begin
      out_strobe_nxt              = 1'b1;
      out_beat_nxt.is_prime       = 1'b0;
      out_beat_nxt.prime_count    = count_r;
      out_beat_nxt.table_overflow = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r         <= ST_IDLE;
      fill_r       <= '0;
      count_r      <= '0;
      root_r       <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      pc_r         <= pc_nxt;
      fill_r       <= fill_nxt;
      count_r      <= count_nxt;
      out_strobe_r <= out_strobe_nxt;
      if (cfg_we) begin
        root_r <= cfg_wdata;
      end
    end
    cand_r     <= cand_nxt;
    k_r        <= k_nxt;
    out_beat_r <= out_beat_nxt;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[fill_r[AW-1:0]] <= PRIME_W'(cand_r);
    end
    if (uw.rd) begin
      rd_data_r <= mem[k_r[AW-1:0]];
    end
  end

  assign out_strobe = out_strobe_r;
  assign out_beat   = out_beat_r;

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= FW'(TABLE_DEPTH))
    else $error("table fill beyond depth");

  a_k_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (pc_r != ST_IDLE && pc_r != ST_CHK) |-> k_r <= fill_r)
    else $error("table walk past fill");

  a_strobe_src: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> ($past(pc_r) == ST_PRIME || $past(pc_r) == ST_COMP))
    else $error("result beat without finishing step");

  a_ovf_prime: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_beat.table_overflow) |-> out_beat.is_prime)
    else $error("overflow flagged on non-prime");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted beat did not start work");

endmodule
